// ----- src/gpd_negative_log_likelihood_assert.svh -----
// assertion macros for the gpd negative log likelihood block
`ifndef GPD_NEGATIVE_LOG_LIKELIHOOD_ASSERT_SVH
`define GPD_NEGATIVE_LOG_LIKELIHOOD_ASSERT_SVH
`ifndef SYNTHESIS
`define GPD_NLL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define GPD_NLL_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define GPD_NLL_ASSERT(lbl, prop, msg)
`define GPD_NLL_NEVER(lbl, cond, msg)
`endif
`endif

// ----- src/gpd_nll_pkg.sv -----
// shared types and constants of the gpd negative log likelihood block
package gpd_nll_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int SUM_W = 48;
  localparam int LOG_W = 37;
  localparam int LN2_Q28 = 186065279;

  typedef struct packed {
    logic [31:0] sample_value;
    logic [31:0] scale_value;
    logic        last_item;
  } gpd_nll_in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] nll_sum;
    logic                    domain_error;
  } gpd_nll_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic calc_n;
    logic flag_bad;
    logic log_start;
    logic log_sel_n;
    logic save_ls;
    logic save_ln;
    logic mul;
    logic div_start;
    logic div_sel_shape;
    logic save_term;
    logic round;
    logic acc;
    logic emit;
  } gpd_nll_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic err_seen;
    logic scale_zero;
    logic shape_zero;
    logic n_bad;
    logic last;
    logic log_done;
    logic div_done;
    logic out_full;
  } gpd_nll_sts_t;

endpackage

// ----- src/gpd_nll_log.sv -----
// iterative natural log unit, result in q30
module gpd_nll_log
  import gpd_nll_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [63:0]      x_i,
  output logic             done_o,
  output logic [LOG_W-1:0] ln_o
);

  typedef enum logic [2:0] {L_IDLE, L_NORM, L_SQ, L_MUL1, L_MUL2} log_state_e;

  log_state_e       state_q;
  logic [63:0]      x_q;
  logic [5:0]       e_q;
  logic [2:0]       step_q;
  logic [4:0]       cnt_q;
  logic [31:0]      m_q;
  logic [29:0]      frac_q;
  logic [57:0]      plo_q;
  logic             done_q;
  logic [LOG_W-1:0] ln_q;

  logic [63:0] sq;
  logic [33:0] e_prod;
  logic [64:0] l_sum;
  logic [63:0] x_d;
  logic [5:0]  e_d;

  assign sq     = 64'(m_q) * 64'(m_q);
  assign e_prod = 34'(e_q) * 34'(LN2_Q28);
  assign l_sum  = 65'({e_prod, 30'b0}) + 65'(plo_q) + (65'(1) << 27);

  // one coarse-to-fine normalization step per cycle
  always_comb begin
    x_d = x_q;
    e_d = e_q;
    case (step_q)
      3'd0: if (x_q[63:32] == '0) begin x_d = x_q << 32; e_d = e_q - 6'd32; end
      3'd1: if (x_q[63:48] == '0) begin x_d = x_q << 16; e_d = e_q - 6'd16; end
      3'd2: if (x_q[63:56] == '0) begin x_d = x_q << 8;  e_d = e_q - 6'd8;  end
      3'd3: if (x_q[63:60] == '0) begin x_d = x_q << 4;  e_d = e_q - 6'd4;  end
      3'd4: if (x_q[63:62] == '0) begin x_d = x_q << 2;  e_d = e_q - 6'd2;  end
      3'd5: if (!x_q[63])         begin x_d = x_q << 1;  e_d = e_q - 6'd1;  end
      default: ;
    endcase
  end

  // normalize, square 30 times, scale by ln2
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
      step_q  <= '0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        L_IDLE: begin
          if (start_i) begin
            x_q     <= x_i;
            e_q     <= 6'd63;
            step_q  <= '0;
            state_q <= L_NORM;
          end
        end
        L_NORM: begin
          x_q    <= x_d;
          e_q    <= e_d;
          step_q <= step_q + 3'd1;
          if (step_q == 3'd5) begin
            state_q <= L_SQ;
            cnt_q   <= '0;
          end
        end
        L_SQ: begin
          if (step_q == 3'd6) begin
            m_q    <= x_q[63:32];
            frac_q <= '0;
            step_q <= '0;
          end else begin
            m_q    <= sq[63] ? sq[63:32] : sq[62:31];
            frac_q <= {frac_q[28:0], sq[63]};
            cnt_q  <= cnt_q + 5'd1;
            if (cnt_q == 5'd29) state_q <= L_MUL1;
          end
        end
        L_MUL1: begin
          plo_q   <= 58'(frac_q) * 58'(LN2_Q28);
          state_q <= L_MUL2;
        end
        L_MUL2: begin
          ln_q    <= l_sum[64:28];
          done_q  <= 1'b1;
          state_q <= L_IDLE;
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign ln_o   = ln_q;

endmodule

// ----- src/gpd_nll_div.sv -----
// restoring divider, one quotient bit per cycle
module gpd_nll_div
  import gpd_nll_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [63:0] num_q;
  logic [31:0] den_q;
  logic [31:0] rem_q;
  logic [32:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem_q, num_q[63]};
  assign fits   = rem_sh >= {1'b0, den_q};

  // quotient bits shift in where numerator bits leave
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        num_q  <= num_i;
        den_q  <= den_i;
        rem_q  <= '0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        rem_q <= fits ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
        num_q <= {num_q[62:0], fits};
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

// ----- src/gpd_nll_ctrl.sv -----
// sequencing controller for one observation at a time
module gpd_nll_ctrl
  import gpd_nll_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  gpd_nll_sts_t sts_i,
  output gpd_nll_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_CALC_N, S_DECIDE, S_LOG_S, S_LOG_N, S_MUL, S_DIV_GO, S_DIV,
    S_ROUND, S_ACC, S_EMIT
  } ctrl_state_e;

  ctrl_state_e  state_q, state_d;
  logic         stall_q, stall_d;
  gpd_nll_cmd_t cmd;

  // next state and commands
  always_comb begin
    state_d = state_q;
    stall_d = stall_q;
    cmd     = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          stall_d  = 1'b1;
          state_d  = S_CALC_N;
        end
      end
      S_CALC_N: begin
        cmd.calc_n = 1'b1;
        state_d    = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts_i.err_seen) begin
          state_d = S_EMIT;
        end else if (sts_i.scale_zero || (!sts_i.shape_zero && sts_i.n_bad)) begin
          cmd.flag_bad = 1'b1;
          state_d      = S_EMIT;
        end else begin
          cmd.log_start = 1'b1;
          state_d       = S_LOG_S;
        end
      end
      S_LOG_S: begin
        if (sts_i.log_done) begin
          cmd.save_ls = 1'b1;
          if (sts_i.shape_zero) begin
            cmd.div_start = 1'b1;
            state_d       = S_DIV;
          end else begin
            cmd.log_start = 1'b1;
            cmd.log_sel_n = 1'b1;
            state_d       = S_LOG_N;
          end
        end
      end
      S_LOG_N: begin
        if (sts_i.log_done) begin
          cmd.save_ln = 1'b1;
          state_d     = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_d = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start     = 1'b1;
        cmd.div_sel_shape = 1'b1;
        state_d           = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd.save_term = 1'b1;
          state_d       = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        state_d   = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!sts_i.last) begin
          stall_d = 1'b0;
          state_d = S_IDLE;
        end else if (!sts_i.out_full) begin
          cmd.emit = 1'b1;
          stall_d  = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and registered stall
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= stall_d;
    end
  end

  assign in_stall_o = stall_q;
  assign cmd_o      = cmd;

endmodule

// ----- src/gpd_nll_dp.sv -----
// datapath: operand registers, log and divide units, accumulator, output register
module gpd_nll_dp
  import gpd_nll_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  input  gpd_nll_in_t  in_data_i,
  input  logic         out_stall_i,
  output logic         out_valid_o,
  output gpd_nll_out_t out_data_o,
  input  gpd_nll_cmd_t cmd_i,
  output gpd_nll_sts_t sts_o
);

  localparam int RND_SH = 30 - FRAC_BITS;
  localparam logic signed [63:0] LOG_OFFS = 64'(FRAC_BITS * 4) * 64'(LN2_Q28);
  localparam logic signed [38:0] LN_4096  = 39'(48) * 39'(LN2_Q28);
  localparam logic [63:0] RND_HALF = 64'(1) << (RND_SH - 1);
  localparam logic signed [63:0] SUM_MAX = 64'((64'(1) << (SUM_W - 1)) - 64'(1));
  localparam logic signed [63:0] SUM_MIN = -(64'(1) << (SUM_W - 1));

  logic signed [15:0]      shape_q;
  logic [31:0]             y_q, s_q;
  logic                    last_q;
  logic signed [48:0]      n_q;
  logic [LOG_W-1:0]        ls_q;
  logic signed [38:0]      la_q;
  logic signed [55:0]      prod_q;
  logic signed [63:0]      total_q, r_q;
  logic signed [SUM_W-1:0] sum_q;
  logic                    err_q;
  gpd_nll_out_t            out_q;
  logic                    out_valid_q;

  logic             log_done, div_done;
  logic [LOG_W-1:0] ln_res;
  logic [63:0]      quo;
  logic [63:0]      log_x, div_num;
  logic [31:0]      div_den;
  logic signed [16:0] shape_ext;
  logic [15:0]      shape_mag;
  logic [63:0]      prod_mag;
  logic             term_neg;
  logic signed [63:0] term;
  logic [63:0]      tot_mag, rnd_mag;
  logic signed [63:0] acc_sum;
  logic signed [48:0] n_calc;

  assign shape_ext = {shape_q[15], shape_q};
  assign shape_mag = shape_q[15] ? 16'(-shape_ext) : shape_q;
  assign prod_mag  = prod_q[55] ? 64'(-prod_q) : 64'(prod_q);
  assign term_neg  = prod_q[55] ^ shape_q[15];
  assign n_calc    = $signed({5'b0, s_q, 12'b0}) + $signed(shape_q) * $signed({1'b0, y_q});

  // operand selection for the shared units
  assign log_x   = cmd_i.log_sel_n ? {16'b0, n_q[47:0]} : {32'b0, s_q};
  assign div_num = cmd_i.div_sel_shape ? prod_mag + 64'(shape_mag >> 1)
                                       : {2'b0, y_q, 30'b0} + 64'(s_q >> 1);
  assign div_den = cmd_i.div_sel_shape ? 32'(shape_mag) : s_q;

  gpd_nll_log u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.log_start),
    .x_i     (log_x),
    .done_o  (log_done),
    .ln_o    (ln_res)
  );

  gpd_nll_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // item total, rounding and saturating sum
  assign term    = (shape_q == '0) ? $signed(quo) : (term_neg ? -$signed(quo) : $signed(quo));
  assign tot_mag = total_q[63] ? 64'(-total_q) : 64'(total_q);
  assign rnd_mag = (tot_mag + RND_HALF) >> RND_SH;
  assign acc_sum = 64'(sum_q) + r_q;

  // operand and intermediate registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      y_q    <= in_data_i.sample_value;
      s_q    <= in_data_i.scale_value;
      last_q <= in_data_i.last_item;
    end
    if (cmd_i.calc_n)    n_q     <= n_calc;
    if (cmd_i.save_ls)   ls_q    <= ln_res;
    if (cmd_i.save_ln)   la_q    <= $signed({2'b0, ln_res}) - $signed({2'b0, ls_q}) - LN_4096;
    if (cmd_i.mul)       prod_q  <= (shape_ext + 17'sd4096) * la_q;
    if (cmd_i.save_term) total_q <= $signed({27'b0, ls_q}) - LOG_OFFS + term;
    if (cmd_i.round)     r_q     <= total_q[63] ? -$signed(rnd_mag) : $signed(rnd_mag);
    if (cmd_i.emit)      out_q   <= '{nll_sum: sum_q, domain_error: err_q};
  end

  // configuration, accumulator and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q     <= '0;
      sum_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) shape_q <= cfg_wdata_i;
      if (cmd_i.flag_bad) begin
        err_q <= 1'b1;
        sum_q <= SUM_MAX[SUM_W-1:0];
      end else if (cmd_i.acc) begin
        if (acc_sum > SUM_MAX) begin
          sum_q <= SUM_MAX[SUM_W-1:0];
          err_q <= 1'b1;
        end else if (acc_sum < SUM_MIN) begin
          sum_q <= SUM_MIN[SUM_W-1:0];
          err_q <= 1'b1;
        end else begin
          sum_q <= acc_sum[SUM_W-1:0];
        end
      end else if (cmd_i.emit) begin
        sum_q <= '0;
        err_q <= 1'b0;
      end
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign sts_o.err_seen   = err_q;
  assign sts_o.scale_zero = (s_q == '0);
  assign sts_o.shape_zero = (shape_q == '0);
  assign sts_o.n_bad      = (n_q <= 0);
  assign sts_o.last       = last_q;
  assign sts_o.log_done   = log_done;
  assign sts_o.div_done   = div_done;
  assign sts_o.out_full   = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- src/gpd_negative_log_likelihood.sv -----
// an accepted item passes through the log unit and then the divider before it is summed;
// both are skipped when the scale is zero, the log argument is not positive or an error is held
// one transaction at a time: the next item is accepted only after the current one is through,
// set by the 30-step squaring log unit (run twice for nonzero shape) and the bit-serial divider
// reset: asynchronous, clears the running sum, error flag, shape and output valid
// top level of the gpd negative log likelihood block
`include "gpd_negative_log_likelihood_assert.svh"
module gpd_negative_log_likelihood
  import gpd_nll_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  gpd_nll_in_t  in_data_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output gpd_nll_out_t out_data_o
);

  gpd_nll_cmd_t cmd;
  gpd_nll_sts_t sts;

  // controller
  gpd_nll_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  gpd_nll_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  // checks
  `GPD_NLL_ASSERT(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o, "not busy")
  `GPD_NLL_ASSERT(a_out_from_emit, $rose(out_valid_o) |-> $past(cmd.emit), "result without emit")
  `GPD_NLL_NEVER(a_no_overwrite, cmd.emit && out_valid_o && out_stall_i, "held result overwritten")

endmodule
